// File: rtl/pgpm_pkg.sv
// pgpm_pkg: widths, constants and the arctangent table shared by the polar grid pupil mask
// used by pgpm_radius, pgpm_cordic and polar_grid_pupil_mask_core
`default_nettype none

package pgpm_pkg;

  // grid and configuration
  localparam int MAX_GRID      = 1024;
  localparam int IDX_W         = 10;
  localparam int GRID_W        = 11;
  localparam int SCALE_W       = 18;
  localparam int MRAD_W        = 18;
  localparam int LEVEL_W       = 16;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COORD_SCALE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_RADIUS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LEVEL  = 4'd3;

  localparam logic [GRID_W-1:0]  GRID_SIZE_RST   = 11'd21;
  localparam logic [SCALE_W-1:0] COORD_SCALE_RST = 18'd6554;
  localparam logic [MRAD_W-1:0]  MASK_RADIUS_RST = 18'd65536;
  localparam logic [LEVEL_W-1:0] MASK_LEVEL_RST  = 16'd256;

  // coordinate mapping
  localparam int DIFF_W      = IDX_W + 1;
  localparam int PROD_W      = DIFF_W + SCALE_W + 1;
  localparam int COORD_W     = 19;
  localparam int COORD_LIMIT = 131072;

  // radius: squares, sum and a one-bit-per-stage square root
  localparam int SQ_W      = 2 * COORD_W - 3;
  localparam int ROOT_W    = 18;
  localparam int SUM_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 1;
  localparam int RADIUS_W  = ROOT_W;
  localparam int RAD_DEPTH = ROOT_W + 3;

  // angle: cordic vectoring
  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_ENTRIES   = 24;
  localparam int ATAN_IDX_W     = 5;
  localparam int ANG_GUARD      = 8;
  localparam int CX_W           = 29;
  localparam int Z_W            = 27;
  localparam int ANGLE_W        = 18;
  localparam int HALF_PI_Q16    = 102944;
  localparam int QUARTER_PI_Q16 = 51472;
  localparam int CORDIC_DEPTH   = CORDIC_STAGES + 2;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(HALF_PI_Q16);
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = ANGLE_W'(-HALF_PI_Q16);
  localparam logic signed [ANGLE_W-1:0] ANGLE_QTR = ANGLE_W'(QUARTER_PI_Q16);

  // both units are padded to a common depth
  localparam int MID_DEPTH  = (RAD_DEPTH > CORDIC_DEPTH) ? RAD_DEPTH : CORDIC_DEPTH;
  localparam int PIPE_DEPTH = MID_DEPTH + 3;

  // atan(2^-i) with 24 fraction bits
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 27'sd13176795;
      5'd1:    v = 27'sd7778716;
      5'd2:    v = 27'sd4110060;
      5'd3:    v = 27'sd2086331;
      5'd4:    v = 27'sd1047214;
      5'd5:    v = 27'sd524117;
      5'd6:    v = 27'sd262123;
      5'd7:    v = 27'sd131069;
      5'd8:    v = 27'sd65536;
      5'd9:    v = 27'sd32768;
      5'd10:   v = 27'sd16384;
      5'd11:   v = 27'sd8192;
      5'd12:   v = 27'sd4096;
      5'd13:   v = 27'sd2048;
      5'd14:   v = 27'sd1024;
      5'd15:   v = 27'sd512;
      5'd16:   v = 27'sd256;
      5'd17:   v = 27'sd128;
      5'd18:   v = 27'sd64;
      5'd19:   v = 27'sd32;
      5'd20:   v = 27'sd16;
      5'd21:   v = 27'sd8;
      5'd22:   v = 27'sd4;
      5'd23:   v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pgpm_radius.sv
// pgpm_radius: pipelined sqrt(x^2+y^2) rounded to nearest, one root bit per stage
// depends on pgpm_pkg; stage loads are driven by the top level
`default_nettype none

module pgpm_radius (
  input  logic                                 clk,
  input  logic [pgpm_pkg::MID_DEPTH-1:0]       adv,
  input  logic signed [pgpm_pkg::COORD_W-1:0]  x,
  input  logic signed [pgpm_pkg::COORD_W-1:0]  y,
  output logic [pgpm_pkg::RADIUS_W-1:0]        radius
);
  import pgpm_pkg::*;

  logic signed [2*COORD_W-1:0] xsq, ysq;
  logic [SQ_W-1:0]             xx_q, yy_q;
  logic [SUM_W-1:0]            sum_q;
  logic [REM_W-1:0]            rem_q [ROOT_W];
  logic [ROOT_W-1:0]           q_q   [ROOT_W];
  logic [SUM_W-1:0]            s_q   [ROOT_W-1];
  logic [RADIUS_W-1:0]         r_q   [RAD_DEPTH-1:MID_DEPTH-1];

  assign xsq = x * x;
  assign ysq = y * y;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      xx_q <= xsq[SQ_W-1:0];
      yy_q <= ysq[SQ_W-1:0];
    end
    if (adv[1]) begin
      sum_q <= {1'b0, xx_q} + {1'b0, yy_q};
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] q_in;
    logic [SUM_W-1:0]  s_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W:0]    trial;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign s_in   = sum_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign q_in   = q_q[j-1];
      assign s_in   = s_q[j-1];
    end

    assign rem_sh = {rem_in, s_in[SUM_W-1 -: 2]};
    assign trial  = {q_in, 2'b01};
    assign take   = (rem_sh >= {1'b0, trial});

    always_ff @(posedge clk) begin
      if (adv[2+j]) begin
        rem_q[j] <= take ? REM_W'(rem_sh - {1'b0, trial}) : REM_W'(rem_sh);
        q_q[j]   <= {q_in[ROOT_W-2:0], take};
      end
    end

    if (j < ROOT_W - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (adv[2+j]) begin
          s_q[j] <= s_in << 2;
        end
      end
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (adv[RAD_DEPTH-1]) begin
      r_q[RAD_DEPTH-1] <= ({1'b0, q_q[ROOT_W-1]} < rem_q[ROOT_W-1]) ?
                          q_q[ROOT_W-1] + 1'b1 : q_q[ROOT_W-1];
    end
  end

  for (genvar k = RAD_DEPTH; k < MID_DEPTH; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        r_q[k] <= r_q[k-1];
      end
    end
  end

  assign radius = r_q[MID_DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/pgpm_cordic.sv
// pgpm_cordic: pipelined half-plane arctangent by cordic vectoring, one iteration per stage
// depends on pgpm_pkg; stage loads are driven by the top level
`default_nettype none

module pgpm_cordic (
  input  logic                                 clk,
  input  logic [pgpm_pkg::MID_DEPTH-1:0]       adv,
  input  logic signed [pgpm_pkg::COORD_W-1:0]  x,
  input  logic signed [pgpm_pkg::COORD_W-1:0]  y,
  output logic signed [pgpm_pkg::ANGLE_W-1:0]  angle
);
  import pgpm_pkg::*;

  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1 << (ANG_GUARD - 1));
  localparam logic signed [Z_W-1:0] Z_HI       = Z_W'(HALF_PI_Q16);
  localparam logic signed [Z_W-1:0] Z_LO       = Z_W'(-HALF_PI_Q16);

  logic signed [CX_W-1:0]    cx_q  [CORDIC_STAGES];
  logic signed [CX_W-1:0]    cy_q  [CORDIC_STAGES];
  logic signed [Z_W-1:0]     z_q   [1:CORDIC_STAGES];
  logic                      spec_q [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] spa_q  [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] a_q    [CORDIC_DEPTH-1:MID_DEPTH-1];

  logic signed [COORD_W-1:0] xn, yn;
  logic                      x_zero, y_zero, y_pos;
  logic signed [ANGLE_W-1:0] spec_ang;
  logic signed [Z_W-1:0]     zr, zc;

  // left half-plane folds onto the right one
  assign xn     = x[COORD_W-1] ? -x : x;
  assign yn     = x[COORD_W-1] ? -y : y;
  assign x_zero = (x == '0);
  assign y_zero = (y == '0);
  assign y_pos  = ~y[COORD_W-1] & ~y_zero;

  always_comb begin
    spec_ang = '0;
    if (x_zero) begin
      if (y_pos) begin
        spec_ang = ANGLE_MAX;
      end else if (y_zero) begin
        spec_ang = ANGLE_QTR;
      end else begin
        spec_ang = ANGLE_MIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cx_q[0]   <= CX_W'(xn) <<< ANG_GUARD;
      cy_q[0]   <= CX_W'(yn) <<< ANG_GUARD;
      spec_q[0] <= x_zero | y_zero;
      spa_q[0]  <= spec_ang;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    logic signed [Z_W-1:0] z_in;
    logic                  cy_pos;

    if (i == 0) begin : g_z0
      assign z_in = '0;
    end else begin : g_zn
      assign z_in = z_q[i];
    end

    assign cy_pos = ~cy_q[i][CX_W-1] & (|cy_q[i]);

    always_ff @(posedge clk) begin
      if (adv[1+i]) begin
        z_q[i+1]    <= cy_pos ? z_in + atan_q24(ATAN_IDX_W'(i)) :
                                z_in - atan_q24(ATAN_IDX_W'(i));
        spec_q[i+1] <= spec_q[i];
        spa_q[i+1]  <= spa_q[i];
      end
    end

    if (i < CORDIC_STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (adv[1+i]) begin
          cx_q[i+1] <= cy_pos ? cx_q[i] + (cy_q[i] >>> i) : cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_pos ? cy_q[i] - (cx_q[i] >>> i) : cy_q[i] + (cx_q[i] >>> i);
        end
      end
    end
  end

  // round half up to 16 fraction bits, then limit to +-pi/2
  assign zr = (z_q[CORDIC_STAGES] + ROUND_HALF) >>> ANG_GUARD;

  always_comb begin
    zc = zr;
    if (zr > Z_HI) begin
      zc = Z_HI;
    end else if (zr < Z_LO) begin
      zc = Z_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[CORDIC_DEPTH-1]) begin
      a_q[CORDIC_DEPTH-1] <= spec_q[CORDIC_STAGES] ? spa_q[CORDIC_STAGES] : ANGLE_W'(zc);
    end
  end

  for (genvar k = CORDIC_DEPTH; k < MID_DEPTH; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        a_q[k] <= a_q[k-1];
      end
    end
  end

  assign angle = a_q[MID_DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/polar_grid_pupil_mask_core.sv
// polar_grid_pupil_mask_core: grid index to normalized x/y, radius, angle and pupil mask
// depends on pgpm_pkg, pgpm_radius and pgpm_cordic
//
// usage:
//  - pixel channel: row_index/col_index with pix_valid, taken at an edge where
//    pix_valid is high and pix_stall is low
//  - result channel: x_coord, y_coord, radius, angle and mask_value with res_valid;
//    the receiver holds res_stall high to keep the current result
//  - config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready are high;
//    cfg_ready is always high, indexes past mask_level are dropped
//  - one request per clock sustained while res_stall is low; pipeline depth is set
//    by the one-bit-per-stage square root, or by the cordic chain when that is the
//    longer of the two
//  - a stalled receiver only backs up the pipeline: empty stages keep filling, and
//    pix_stall rises once every stage holds a request
//  - reset empties the pipeline and loads the default register values
//  - user must write config only while no request is in flight; core does not check
`default_nettype none

module polar_grid_pupil_mask_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // pixel requests
  input  logic                                  pix_valid,
  output logic                                  pix_stall,
  input  logic [pgpm_pkg::IDX_W-1:0]            row_index,
  input  logic [pgpm_pkg::IDX_W-1:0]            col_index,
  // results
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic signed [pgpm_pkg::COORD_W-1:0]   x_coord,
  output logic signed [pgpm_pkg::COORD_W-1:0]   y_coord,
  output logic [pgpm_pkg::RADIUS_W-1:0]         radius,
  output logic signed [pgpm_pkg::ANGLE_W-1:0]   angle,
  output logic [pgpm_pkg::LEVEL_W-1:0]          mask_value,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pgpm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pgpm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pgpm_pkg::*;

  localparam logic signed [PROD_W-1:0]  P_HI = PROD_W'(COORD_LIMIT);
  localparam logic signed [PROD_W-1:0]  P_LO = PROD_W'(-COORD_LIMIT);
  localparam logic signed [COORD_W-1:0] C_HI = COORD_W'(COORD_LIMIT);
  localparam logic signed [COORD_W-1:0] C_LO = COORD_W'(-COORD_LIMIT);

  // centre index floor((n-1)/2), n limited to the largest grid
  function automatic logic [IDX_W-1:0] centre_of(input logic [GRID_W-1:0] n_raw);
    logic [GRID_W-1:0] n;
    logic [GRID_W-1:0] nm1;
    n   = (int'(n_raw) > MAX_GRID) ? GRID_W'(MAX_GRID) : n_raw;
    nm1 = (n == '0) ? '0 : n - 1'b1;
    return IDX_W'(nm1 >> 1);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [COORD_W-1:0] c;
    if (p > P_HI) begin
      c = C_HI;
    end else if (p < P_LO) begin
      c = C_LO;
    end else begin
      c = COORD_W'(p);
    end
    return c;
  endfunction

  // config registers; the grid size is kept as its centre index
  logic [IDX_W-1:0]   centre;
  logic [SCALE_W-1:0] coord_scale;
  logic [MRAD_W-1:0]  mask_radius;
  logic [LEVEL_W-1:0] mask_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre      <= centre_of(GRID_SIZE_RST);
      coord_scale <= COORD_SCALE_RST;
      mask_radius <= MASK_RADIUS_RST;
      mask_level  <= MASK_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_SIZE:   centre      <= centre_of(cfg_data[GRID_W-1:0]);
        CFG_COORD_SCALE: coord_scale <= cfg_data[SCALE_W-1:0];
        CFG_MASK_RADIUS: mask_radius <= cfg_data[MRAD_W-1:0];
        CFG_MASK_LEVEL:  mask_level  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or everything past it can move
  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH-1:0] en;

  for (genvar i = 0; i < PIPE_DEPTH; i++) begin : g_en
    assign en[i] = ~res_stall | ~(&v[PIPE_DEPTH-1:i]);
  end

  assign pix_stall = ~en[0];
  assign res_valid = v[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pix_valid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: offset from centre times scale
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [SCALE_W:0]   scale_s;
  logic signed [PROD_W-1:0]  prod_x, prod_y;

  assign dx      = $signed({1'b0, row_index}) - $signed({1'b0, centre});
  assign dy      = $signed({1'b0, col_index}) - $signed({1'b0, centre});
  assign scale_s = $signed({1'b0, coord_scale});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_x <= dx * scale_s;
      prod_y <= dy * scale_s;
    end
  end

  // stage 1: saturate to the coordinate range
  logic signed [COORD_W-1:0] x_q, y_q;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_q <= clamp_coord(prod_x);
      y_q <= clamp_coord(prod_y);
    end
  end

  // middle stages: radius and angle side by side, coordinates carried along
  logic [MID_DEPTH-1:0]       adv;
  logic [RADIUS_W-1:0]        r_mid;
  logic signed [ANGLE_W-1:0]  a_mid;
  logic signed [COORD_W-1:0]  xd [MID_DEPTH];
  logic signed [COORD_W-1:0]  yd [MID_DEPTH];

  assign adv = en[MID_DEPTH+1:2];

  pgpm_radius u_radius (
    .clk    (clk),
    .adv    (adv),
    .x      (x_q),
    .y      (y_q),
    .radius (r_mid)
  );

  pgpm_cordic u_cordic (
    .clk   (clk),
    .adv   (adv),
    .x     (x_q),
    .y     (y_q),
    .angle (a_mid)
  );

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      xd[0] <= x_q;
      yd[0] <= y_q;
    end
  end

  for (genvar k = 1; k < MID_DEPTH; k++) begin : g_xy_dly
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        xd[k] <= xd[k-1];
        yd[k] <= yd[k-1];
      end
    end
  end

  // last stage: pupil test and output register
  always_ff @(posedge clk) begin
    if (en[PIPE_DEPTH-1]) begin
      x_coord    <= xd[MID_DEPTH-1];
      y_coord    <= yd[MID_DEPTH-1];
      radius     <= r_mid;
      angle      <= a_mid;
      mask_value <= (r_mid <= mask_radius) ? mask_level : '0;
    end
  end

`ifndef ASSERT_OFF
  // input is held off only when every stage holds a request
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (&v))
    else $error("pixel channel stalled with an empty pipeline stage");

  // outside the pupil the mask must be zero
  a_mask_outside: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (radius > mask_radius)) |-> (mask_value == '0))
    else $error("nonzero mask value outside the pupil radius");

  // half-plane angle stays within +-pi/2
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((angle <= ANGLE_MAX) && (angle >= ANGLE_MIN)))
    else $error("angle outside -pi/2..pi/2");

  // origin gives zero radius and the pi/4 angle
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (x_coord == '0) && (y_coord == '0)) |->
      ((radius == '0) && (angle == ANGLE_QTR)))
    else $error("radius or angle wrong at the origin");
`endif

endmodule

`default_nettype wire
